[rtl/fsdt_pkg.sv]
// ----------------------------------------------------------------------------
// fsdt_pkg
// Shared constants and types of the frame stamped depth test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fsdt_pkg;

   localparam int DefaultWidth  = 800;
   localparam int DefaultHeight = 480;

   localparam int DepthW = 16;
   localparam int StampW = 8;

   localparam logic [1:0] CmdBegin = 2'd0;
   localparam logic [1:0] CmdFill  = 2'd1;
   localparam logic [1:0] CmdEdge  = 2'd2;

   typedef logic [DepthW-1:0] depth_type;
   typedef logic [StampW-1:0] stamp_type;

   typedef struct packed {
      stamp_type stamp;
      depth_type depth;
   } entry_type;

endpackage

`default_nettype wire

[rtl/fsdt_store.sv]
// ----------------------------------------------------------------------------
// fsdt_store
// Per-pixel depth and stamp memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fsdt_store #(
   parameter int Entries = fsdt_pkg::DefaultWidth * fsdt_pkg::DefaultHeight,
   parameter int AddrW   = (Entries > 1) ? $clog2(Entries) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   output      logic                ready,
   input  wire logic                rd_en,
   input  wire logic [AddrW-1:0]    rd_addr,
   output      fsdt_pkg::entry_type rd_data,
   input  wire logic                wr_en,
   input  wire logic [AddrW-1:0]    wr_addr,
   input  wire fsdt_pkg::entry_type wr_data
);
   import fsdt_pkg::*;

   localparam logic [AddrW-1:0] LastAddr = AddrW'(Entries - 1);

   entry_type        mem [Entries];
   entry_type        rd_data_ff;
   logic             clearing_ff;
   logic [AddrW-1:0] clr_addr_ff;

   // sweep every entry to a zero stamp, then hand the port over
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clr_addr_ff == LastAddr) begin
            clearing_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AddrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clearing_ff;

endmodule

`default_nettype wire

[rtl/frame_stamped_depth_test_unit.sv]
// ----------------------------------------------------------------------------
// frame_stamped_depth_test_unit
// Per-pixel depth test with lazy clearing by frame stamp.
//
// Commands enter on the req_ ports and are taken at a clock edge where start
// is high and busy is low. Begin frame advances the frame tag (zero skipped
// on wrap). Fill passes when the clamped depth is strictly nearer than the
// stored one and then writes depth and stamp; edge passes on greater or
// equal and writes nothing to the store. A stored depth whose stamp differs
// from the current tag reads as zero.
// Every command gives one beat on the rsp_ ports, marked by rsp_strobe for
// one cycle; rsp_write_enable says whether the pixel is drawn. One command
// is in flight at a time; a command passes address multiply, memory read,
// test and write back, and a registered result.
// The receiver cannot stall; results are never held.
// After reset busy stays high while all WIDTH*HEIGHT entries of the stamp
// memory are swept to zero, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_stamped_depth_test_unit #(
   parameter int WIDTH  = fsdt_pkg::DefaultWidth,
   parameter int HEIGHT = fsdt_pkg::DefaultHeight
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [10:0] req_pixel_x,
   input  wire logic signed [10:0] req_pixel_y,
   input  wire logic signed [17:0] req_depth,
   input  wire logic [15:0]        req_color,
   output      logic               rsp_strobe,
   output      logic               rsp_write_enable,
   output      logic [9:0]         rsp_out_x,
   output      logic [9:0]         rsp_out_y,
   output      logic [15:0]        rsp_out_color
);
   import fsdt_pkg::*;

   localparam int Entries = WIDTH * HEIGHT;
   localparam int AddrW   = (Entries > 1) ? $clog2(Entries) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_TEST = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       cmd_ff;
   logic signed [10:0] x_ff, y_ff;
   depth_type        dc_ff, dc_in;
   logic [15:0]      color_ff;
   logic             hit_ff;
   logic [AddrW-1:0] addr_ff;
   stamp_type        tag_ff, tag_in;

   logic             rsp_strobe_ff;
   logic             rsp_we_ff;
   logic [9:0]       rsp_x_ff, rsp_y_ff;
   logic [15:0]      rsp_color_ff;

   logic             store_ready;
   entry_type        rd_data;
   entry_type        wr_data;
   logic             wr_en;
   logic             accept;
   logic             x_in_range, y_in_range;
   depth_type        stored;
   logic             pass;

   fsdt_store #(
      .Entries(Entries),
      .AddrW  (AddrW)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .ready  (store_ready),
      .rd_en  (state_ff == S_READ),
      .rd_addr(addr_ff),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(addr_ff),
      .wr_data(wr_data)
   );

   assign busy   = (state_ff != S_IDLE) | ~store_ready;
   assign accept = start & ~busy;

   always_comb begin
      if (req_depth[17]) begin
         dc_in = '0;
      end else if (req_depth[16]) begin
         dc_in = '1;
      end else begin
         dc_in = req_depth[15:0];
      end
   end

   assign x_in_range = ~x_ff[10] & (x_ff[9:0] < 10'(WIDTH));
   assign y_in_range = ~y_ff[10] & (y_ff[9:0] < 10'(HEIGHT));

   assign stored = (rd_data.stamp == tag_ff) ? rd_data.depth : '0;

   always_comb begin
      case (cmd_ff)
         CmdFill: pass = hit_ff & (dc_ff > stored);
         CmdEdge: pass = hit_ff & (dc_ff >= stored);
         default: pass = 1'b0;
      endcase
   end

   assign wr_en   = (state_ff == S_TEST) & pass & (cmd_ff == CmdFill);
   assign wr_data = '{stamp: tag_ff, depth: dc_ff};

   always_comb begin
      tag_in = tag_ff;
      if ((state_ff == S_TEST) && (cmd_ff == CmdBegin)) begin
         tag_in = (tag_ff == '1) ? stamp_type'(1) : tag_ff + stamp_type'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_ADDR;
         end
         S_ADDR:  state_in = S_READ;
         S_READ:  state_in = S_TEST;
         S_TEST:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tag_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tag_ff        <= tag_in;
         rsp_strobe_ff <= (state_ff == S_TEST);
      end
   end

   // latch the command beat
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         x_ff     <= req_pixel_x;
         y_ff     <= req_pixel_y;
         dc_ff    <= dc_in;
         color_ff <= req_color;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ADDR) begin
         hit_ff  <= (cmd_ff inside {CmdFill, CmdEdge}) & x_in_range & y_in_range;
         addr_ff <= AddrW'(y_ff[9:0]) * AddrW'(WIDTH) + AddrW'(x_ff[9:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_TEST) begin
         rsp_we_ff    <= pass;
         rsp_x_ff     <= pass ? x_ff[9:0] : '0;
         rsp_y_ff     <= pass ? y_ff[9:0] : '0;
         rsp_color_ff <= pass ? color_ff : '0;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_out_color    = rsp_color_ff;

endmodule

`default_nettype wire

[verif/tb_frame_stamped_depth_test_unit.sv]
// ----------------------------------------------------------------------------
// tb_frame_stamped_depth_test_unit
// Self-checking bench for the frame stamped depth test unit. A short table of
// hand-picked commands covers fill and edge tests, ties, depth clamping,
// off-screen pixels, the unused command and the lazy clear at begin frame.
// Random traffic follows. It aims mostly at a few hot pixels with clustered
// depths and includes a run of begin frames that wraps the frame tag. Each
// result beat is checked field by field against the draw given in the table
// or, elsewhere, against a shadow of the depth and stamp stores kept in the bench.
// ----------------------------------------------------------------------------
module tb_frame_stamped_depth_test_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fsdt_pkg::*;

   localparam int Width      = DefaultWidth;
   localparam int Height     = DefaultHeight;
   localparam int PhaseBeats = 560;
   localparam int TagWrap    = 255;
   localparam int StallLimit = 1_200_000;

   localparam logic [1:0] CmdUnused = 2'd3;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic signed [17:0] depth;
      logic [15:0]        color;
   } pixel_cmd_type;

   typedef struct packed {
      logic       write_en;
      logic [9:0] col;
      logic [9:0] row;
      logic [15:0] rgb;
   } draw_type;

   typedef struct {
      pixel_cmd_type beat;
      bit            typed;
      draw_type      draw;
   } step_row_type;

   localparam draw_type NoDraw = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = CmdBegin;
   logic signed [10:0] req_pixel_x = '0;
   logic signed [10:0] req_pixel_y = '0;
   logic signed [17:0] req_depth = '0;
   logic [15:0] req_color = '0;
   logic rsp_strobe;
   logic rsp_write_enable;
   logic [9:0] rsp_out_x;
   logic [9:0] rsp_out_y;
   logic [15:0] rsp_out_color;

   bit [15:0] shadow_depth [Width*Height];
   bit [7:0]  shadow_stamp [Width*Height];
   bit [7:0]  shadow_tag;

   draw_type pending_draws [$];
   draw_type want;
   int mismatches = 0;
   int quiet_cycles = 0;

   step_row_type directed_steps [23] = '{
      '{'{CmdBegin,  11'sd0,    11'sd0,    18'sd0,       16'h0000}, 1'b1, NoDraw},
      '{'{CmdFill,   11'sd0,    11'sd0,    18'sd100,     16'h1234}, 1'b1,
        '{1'b1, 10'd0, 10'd0, 16'h1234}},
      '{'{CmdFill,   11'sd0,    11'sd0,    18'sd100,     16'h5555}, 1'b1, NoDraw},
      '{'{CmdEdge,   11'sd0,    11'sd0,    18'sd100,     16'hABCD}, 1'b1,
        '{1'b1, 10'd0, 10'd0, 16'hABCD}},
      '{'{CmdEdge,   11'sd0,    11'sd0,    18'sd99,      16'h0F0F}, 1'b1, NoDraw},
      '{'{CmdFill,   11'sd799,  11'sd479,  18'sd131071,  16'hFFFF}, 1'b1,
        '{1'b1, 10'd799, 10'd479, 16'hFFFF}},
      '{'{CmdFill,   11'sd799,  11'sd479,  18'sd65535,   16'h0001}, 1'b1, NoDraw},
      '{'{CmdEdge,   11'sd799,  11'sd479,  18'sd65535,   16'h0000}, 1'b1,
        '{1'b1, 10'd799, 10'd479, 16'h0000}},
      '{'{CmdFill,   11'sd1,    11'sd0,    -18'sd65536,  16'h2222}, 1'b1, NoDraw},
      '{'{CmdEdge,   11'sd1,    11'sd0,    -18'sd1,      16'h3333}, 1'b1,
        '{1'b1, 10'd1, 10'd0, 16'h3333}},
      '{'{CmdFill,   11'sd800,  11'sd0,    18'sd500,     16'h4444}, 1'b1, NoDraw},
      '{'{CmdFill,   -11'sd1,   11'sd0,    18'sd500,     16'h4444}, 1'b1, NoDraw},
      '{'{CmdFill,   11'sd0,    11'sd480,  18'sd500,     16'h4444}, 1'b1, NoDraw},
      '{'{CmdEdge,   11'h400,   11'sd1023, 18'sd65535,   16'h4444}, 1'b1, NoDraw},
      '{'{CmdUnused, 11'sd0,    11'sd0,    18'sd65535,   16'h5A5A}, 1'b1, NoDraw},
      '{'{CmdFill,   11'sd0,    11'sd0,    18'sd101,     16'h6666}, 1'b0, NoDraw},
      '{'{CmdBegin,  11'sd0,    11'sd0,    18'sd0,       16'h0000}, 1'b1, NoDraw},
      '{'{CmdFill,   11'sd0,    11'sd0,    18'sd1,       16'h7777}, 1'b1,
        '{1'b1, 10'd0, 10'd0, 16'h7777}},
      '{'{CmdEdge,   11'sd799,  11'sd479,  18'sd0,       16'h8888}, 1'b1,
        '{1'b1, 10'd799, 10'd479, 16'h8888}},
      '{'{CmdFill,   11'sd1023, 11'h400,   18'sd0,       16'h9999}, 1'b1, NoDraw},
      '{'{CmdFill,   11'sd512,  11'sd256,  18'sd65536,   16'hAAAA}, 1'b1,
        '{1'b1, 10'd512, 10'd256, 16'hAAAA}},
      '{'{CmdFill,   11'sd512,  11'sd256,  18'sd65535,   16'hBBBB}, 1'b1, NoDraw},
      '{'{CmdEdge,   11'sd0,    11'sd0,    18'sd0,       16'hCCCC}, 1'b0, NoDraw}
   };

   frame_stamped_depth_test_unit #(
      .WIDTH (Width),
      .HEIGHT(Height)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_depth       (req_depth),
      .req_color       (req_color),
      .rsp_strobe      (rsp_strobe),
      .rsp_write_enable(rsp_write_enable),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_color   (rsp_out_color)
   );

   always #6ns clock = ~clock;

   function automatic draw_type predict_draw(input pixel_cmd_type b);
      draw_type d;
      int idx;
      logic [15:0] near;
      logic [15:0] held;
      bit pass;
      d = NoDraw;
      if (b.cmd == CmdBegin) begin
         shadow_tag = shadow_tag + 8'd1;
         if (shadow_tag == 8'd0) shadow_tag = 8'd1;
         return d;
      end
      if (b.cmd != CmdFill && b.cmd != CmdEdge) return d;
      if (b.x < 0 || b.x >= Width || b.y < 0 || b.y >= Height) return d;
      if (b.depth < 0) near = '0;
      else if (b.depth > 65535) near = '1;
      else near = b.depth[15:0];
      idx = int'(b.y) * Width + int'(b.x);
      held = (shadow_stamp[idx] == shadow_tag) ? shadow_depth[idx] : 16'd0;
      if (b.cmd == CmdFill) begin
         pass = near > held;
         if (pass) begin
            shadow_depth[idx] = near;
            shadow_stamp[idx] = shadow_tag;
         end
      end else begin
         pass = near >= held;
      end
      if (pass) d = '{1'b1, b.x[9:0], b.y[9:0], b.color};
      return d;
   endfunction

   function automatic pixel_cmd_type random_beat();
      pixel_cmd_type b;
      logic [31:0] noise;
      int pick;
      b.color = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 16) b.cmd = CmdBegin;
      else if (pick < 18) b.cmd = CmdUnused;
      else if (pick < 60) b.cmd = CmdFill;
      else b.cmd = CmdEdge;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         b.x = 11'($urandom_range(0, 1));
         b.y = 11'($urandom_range(0, 1));
      end else if (pick < 70) begin
         b.x = ($urandom_range(0, 1) != 0) ? 11'(Width - 1) : 11'sd0;
         b.y = ($urandom_range(0, 1) != 0) ? 11'(Height - 1) : 11'sd0;
      end else if (pick < 85) begin
         b.x = 11'($urandom_range(0, Width - 1));
         b.y = 11'($urandom_range(0, Height - 1));
      end else begin
         noise = $urandom;
         b.x = noise[10:0];
         b.y = noise[26:16];
      end
      pick = $urandom_range(0, 99);
      noise = $urandom;
      if (pick < 45) b.depth = 18'($urandom_range(0, 7));
      else if (pick < 60) b.depth = 18'($urandom_range(65530, 65541));
      else if (pick < 78) b.depth = 18'($urandom_range(0, 65535));
      else if (pick < 88) b.depth = 18'(0 - int'($urandom_range(1, 65536)));
      else b.depth = noise[17:0];
      return b;
   endfunction

   task automatic issue(input pixel_cmd_type b, input bit typed, input draw_type typed_draw);
      draw_type guess;
      req_cmd     <= b.cmd;
      req_pixel_x <= b.x;
      req_pixel_y <= b.y;
      req_depth   <= b.depth;
      req_color   <= b.color;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      guess = predict_draw(b);
      pending_draws.push_back(typed ? typed_draw : guess);
   endtask

   task automatic hold_off(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_draws();
      start <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_draws.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing expected, actual we %0b x %0d y %0d color %h",
                     $time, rsp_write_enable, rsp_out_x, rsp_out_y, rsp_out_color);
         end else begin
            want = pending_draws.pop_front();
            check_field("write_enable", 32'(want.write_en), 32'(rsp_write_enable));
            check_field("out_x", 32'(want.col), 32'(rsp_out_x));
            check_field("out_y", 32'(want.row), 32'(rsp_out_y));
            check_field("out_color", 32'(want.rgb), 32'(rsp_out_color));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("tb_frame_stamped_depth_test_unit NOT OK");
         $finish;
      end
   end

   initial begin
      pixel_cmd_type beat;
      int idle_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         hold_off(28);
         issue(directed_steps[i].beat, directed_steps[i].typed, directed_steps[i].draw);
      end

      for (int phase = 0; phase < 3; phase++) begin
         drain_draws();
         idle_pct = (phase == 0) ? 28 : (phase == 1) ? 75 : 0;
         for (int n = 0; n < PhaseBeats; n++) begin
            hold_off(idle_pct);
            if (phase == 1 && n == 100) begin
               // wrap the frame tag so stale stamps alias the current frame
               for (int k = 0; k < TagWrap; k++) begin
                  beat = random_beat();
                  beat.cmd = CmdBegin;
                  issue(beat, 1'b0, NoDraw);
               end
            end
            issue(random_beat(), 1'b0, NoDraw);
         end
      end

      drain_draws();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_frame_stamped_depth_test_unit OK");
      end else begin
         $display("tb_frame_stamped_depth_test_unit NOT OK");
      end
      $finish;
   end

endmodule

[frame_stamped_depth_test_unit.f]
rtl/fsdt_pkg.sv
rtl/fsdt_store.sv
rtl/frame_stamped_depth_test_unit.sv
verif/tb_frame_stamped_depth_test_unit.sv
